### hw/rtl/tmfp_pkg.sv
// Shared types and constants of the timestamped MAVLink log framer.
`default_nettype none

package tmfp_pkg;

    localparam int DEFAULT_COUNT_WIDTH = 32;

    // Result queue between the decoder and the output register.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Frame markers and header layout.
    localparam logic [7:0] MARKER_V2      = 8'hFD;
    localparam logic [7:0] MARKER_V1      = 8'hFE;
    localparam logic [7:0] FLAG_SIGNED    = 8'h01;
    localparam logic [3:0] TS_BYTES       = 4'd8;
    localparam logic [3:0] HDR_LEN_AT     = 4'd1;
    localparam logic [3:0] HDR_FLAGS_AT   = 4'd2;
    localparam logic [3:0] V2_ID_LO_AT    = 4'd7;
    localparam logic [3:0] V2_ID_MID_AT   = 4'd8;
    localparam logic [3:0] V2_ID_HI_AT    = 4'd9;
    localparam logic [3:0] V2_HEADER_LAST = 4'd9;
    localparam logic [3:0] V1_ID_AT       = 4'd5;
    localparam logic [3:0] V1_HEADER_LAST = 4'd5;
    localparam logic [8:0] CHECKSUM_LEN   = 9'd2;
    localparam logic [8:0] SIGNATURE_LEN  = 9'd13;

    typedef enum logic [2:0] {
        PH_TIME    = 3'd0,
        PH_HEADER  = 3'd1,
        PH_PAYLOAD = 3'd2,
        PH_TRAILER = 3'd3
    } tmfp_phase_t;

    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_COUNT   = 2'd2
    } tmfp_kind_t;

    typedef struct packed {
        tmfp_kind_t  kind;
        logic [63:0] timestamp;
        logic [23:0] message_id;
        logic [7:0]  payload_length;
        logic [7:0]  payload_byte;
        logic        last_of_message;
        logic [31:0] message_total;
    } tmfp_result_t;

    // Everything one input byte produces: an optional header or payload word
    // and an optional message count word.
    typedef struct packed {
        logic         has_main;
        tmfp_result_t main;
        logic         has_count;
        logic [31:0]  total;
    } tmfp_entry_t;

    typedef struct packed {
        logic full;
        logic almost_full;
    } tmfp_queue_status_t;

endpackage

`default_nettype wire

### hw/rtl/tmfp_frame_decoder.sv
// Input register and per-byte framing state machine of the log framer.
`default_nettype none

module tmfp_frame_decoder #(
    parameter int COUNT_WIDTH = tmfp_pkg::DEFAULT_COUNT_WIDTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [7:0]                   data_byte,
    input  logic                         end_of_stream,
    input  logic [31:0]                  max_reports,
    input  tmfp_pkg::tmfp_queue_status_t queue_status,
    output logic                         push,
    output tmfp_pkg::tmfp_entry_t        entry
);
    import tmfp_pkg::*;

    logic                   in_valid_reg;
    logic [7:0]             byte_reg;
    logic                   eos_reg;

    tmfp_phase_t            phase_reg, phase_next;
    logic [63:0]            time_window_reg, time_window_next;
    logic [3:0]             window_fill_reg, window_fill_next;
    logic                   is_v2_reg, is_v2_next;
    logic [3:0]             header_index_reg, header_index_next;
    logic [7:0]             held_length_reg, held_length_next;
    logic [7:0]             held_flags_reg, held_flags_next;
    logic [23:0]            held_id_reg, held_id_next;
    logic [8:0]             skip_reg, skip_next;
    logic                   reporting_reg, reporting_next;
    logic [COUNT_WIDTH-1:0] seen_reg, seen_next;
    logic [31:0]            sent_reg, sent_next;

    logic                   accept;
    logic                   done;
    logic                   report;
    logic [23:0]            id_now;
    logic [8:0]             trailer_len;
    logic [8:0]             skip_dec;
    logic [COUNT_WIDTH+31:0] seen_ext;

    // An item may enter only if the queue has room for it and for the one
    // already sitting in the input register.
    assign in_stall = queue_status.full || (queue_status.almost_full && in_valid_reg);
    assign accept   = in_valid && !in_stall;

    assign trailer_len = CHECKSUM_LEN +
        ((is_v2_reg && ((held_flags_reg & FLAG_SIGNED) != 8'd0)) ? SIGNATURE_LEN : 9'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            phase_reg        <= PH_TIME;
            time_window_reg  <= '0;
            window_fill_reg  <= '0;
            is_v2_reg        <= 1'b0;
            header_index_reg <= '0;
            held_length_reg  <= '0;
            held_flags_reg   <= '0;
            held_id_reg      <= '0;
            skip_reg         <= '0;
            reporting_reg    <= 1'b0;
            seen_reg         <= '0;
            sent_reg         <= '0;
        end
        else
        begin
            in_valid_reg     <= accept;
            phase_reg        <= phase_next;
            time_window_reg  <= time_window_next;
            window_fill_reg  <= window_fill_next;
            is_v2_reg        <= is_v2_next;
            header_index_reg <= header_index_next;
            held_length_reg  <= held_length_next;
            held_flags_reg   <= held_flags_next;
            held_id_reg      <= held_id_next;
            skip_reg         <= skip_next;
            reporting_reg    <= reporting_next;
            seen_reg         <= seen_next;
            sent_reg         <= sent_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= data_byte;
            eos_reg  <= end_of_stream;
        end
    end

    always_comb
    begin
        phase_next        = phase_reg;
        time_window_next  = time_window_reg;
        window_fill_next  = window_fill_reg;
        is_v2_next        = is_v2_reg;
        header_index_next = header_index_reg;
        held_length_next  = held_length_reg;
        held_flags_next   = held_flags_reg;
        held_id_next      = held_id_reg;
        skip_next         = skip_reg;
        reporting_next    = reporting_reg;
        seen_next         = seen_reg;
        sent_next         = sent_reg;
        entry             = '0;
        done              = 1'b0;
        report            = 1'b0;
        id_now            = held_id_reg;
        skip_dec          = skip_reg;
        seen_ext          = '0;

        if (in_valid_reg)
        begin
            unique case (phase_reg)
                PH_TIME:
                begin
                    if (window_fill_reg >= TS_BYTES &&
                        (byte_reg == MARKER_V2 || byte_reg == MARKER_V1))
                    begin
                        is_v2_next        = (byte_reg == MARKER_V2);
                        header_index_next = HDR_LEN_AT;
                        held_length_next  = '0;
                        held_flags_next   = '0;
                        held_id_next      = '0;
                        phase_next        = PH_HEADER;
                    end
                    else
                    begin
                        // Not a marker: slide the timestamp window by one byte.
                        time_window_next = {time_window_reg[55:0], byte_reg};
                        if (window_fill_reg < TS_BYTES)
                        begin
                            window_fill_next = window_fill_reg + 4'd1;
                        end
                    end
                end
                PH_HEADER:
                begin
                    if (header_index_reg == HDR_LEN_AT)
                    begin
                        held_length_next = byte_reg;
                    end
                    if (is_v2_reg)
                    begin
                        if (header_index_reg == HDR_FLAGS_AT)
                        begin
                            held_flags_next = byte_reg;
                        end
                        if (header_index_reg == V2_ID_LO_AT)
                        begin
                            id_now[7:0] = byte_reg;
                        end
                        if (header_index_reg == V2_ID_MID_AT)
                        begin
                            id_now[15:8] = byte_reg;
                        end
                        if (header_index_reg == V2_ID_HI_AT)
                        begin
                            id_now[23:16] = byte_reg;
                        end
                        done = (header_index_reg >= V2_HEADER_LAST);
                    end
                    else
                    begin
                        if (header_index_reg == V1_ID_AT)
                        begin
                            id_now[7:0] = byte_reg;
                        end
                        done = (header_index_reg >= V1_HEADER_LAST);
                    end
                    held_id_next = id_now;

                    if (!done)
                    begin
                        header_index_next = header_index_reg + 4'd1;
                    end
                    else
                    begin
                        if (seen_reg != '1)
                        begin
                            seen_next = seen_reg + COUNT_WIDTH'(1);
                        end
                        report         = (sent_reg < max_reports);
                        reporting_next = report;
                        if (report)
                        begin
                            entry.has_main             = 1'b1;
                            entry.main.kind            = KIND_HEADER;
                            entry.main.timestamp       = time_window_reg;
                            entry.main.message_id      = id_now;
                            entry.main.payload_length  = held_length_reg;
                            entry.main.last_of_message = (held_length_reg == 8'd0);
                            sent_next                  = sent_reg + 32'd1;
                        end
                        if (held_length_reg != 8'd0)
                        begin
                            phase_next = PH_PAYLOAD;
                            skip_next  = {1'b0, held_length_reg};
                        end
                        else
                        begin
                            phase_next = PH_TRAILER;
                            skip_next  = trailer_len;
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    if (reporting_reg)
                    begin
                        entry.has_main             = 1'b1;
                        entry.main.kind            = KIND_PAYLOAD;
                        entry.main.timestamp       = time_window_reg;
                        entry.main.message_id      = held_id_reg;
                        entry.main.payload_length  = held_length_reg;
                        entry.main.payload_byte    = byte_reg;
                        entry.main.last_of_message = (skip_reg <= 9'd1);
                    end
                    if (skip_reg != 9'd0)
                    begin
                        skip_dec = skip_reg - 9'd1;
                    end
                    if (skip_dec == 9'd0)
                    begin
                        phase_next = PH_TRAILER;
                        skip_next  = trailer_len;
                    end
                    else
                    begin
                        skip_next = skip_dec;
                    end
                end
                PH_TRAILER:
                begin
                    if (skip_reg != 9'd0)
                    begin
                        skip_dec = skip_reg - 9'd1;
                    end
                    skip_next = skip_dec;
                    if (skip_dec == 9'd0)
                    begin
                        phase_next       = PH_TIME;
                        window_fill_next = '0;
                        time_window_next = '0;
                        reporting_next   = 1'b0;
                    end
                end
                default:
                begin
                    phase_next       = PH_TIME;
                    window_fill_next = '0;
                    time_window_next = '0;
                end
            endcase

            if (eos_reg)
            begin
                // The count word reports the total after this byte, capped to 32 bits.
                seen_ext        = {32'd0, seen_next};
                entry.has_count = 1'b1;
                entry.total     = (seen_ext[COUNT_WIDTH+31:32] != '0) ? 32'hFFFF_FFFF
                                                                      : seen_ext[31:0];
                phase_next        = PH_TIME;
                time_window_next  = '0;
                window_fill_next  = '0;
                is_v2_next        = 1'b0;
                header_index_next = '0;
                held_length_next  = '0;
                held_flags_next   = '0;
                held_id_next      = '0;
                skip_next         = '0;
                reporting_next    = 1'b0;
                seen_next         = '0;
                sent_next         = '0;
            end
        end
    end

    assign push = in_valid_reg && (entry.has_main || entry.has_count);

endmodule

`default_nettype wire

### hw/rtl/tmfp_result_queue.sv
// Result queue and output register that turns queue entries into output words.
`default_nettype none

module tmfp_result_queue (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  tmfp_pkg::tmfp_entry_t        entry,
    output tmfp_pkg::tmfp_queue_status_t queue_status,
    output logic                         out_valid,
    input  logic                         out_stall,
    output tmfp_pkg::tmfp_result_t       result
);
    import tmfp_pkg::*;

    tmfp_entry_t            slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   main_done_reg, main_done_next;
    tmfp_result_t           result_reg, result_next;
    tmfp_entry_t            head;
    logic                   pop;

    assign queue_status.full        = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign queue_status.almost_full = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH - 1));
    assign head                     = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            main_done_reg <= 1'b0;
        end
        else
        begin
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            main_done_reg <= main_done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        main_done_next = main_done_reg;
        result_next    = result_reg;
        pop            = 1'b0;

        if (!out_valid_reg || !out_stall)
        begin
            out_valid_next = 1'b0;
            if (count_reg != '0)
            begin
                out_valid_next = 1'b1;
                if (head.has_main && !main_done_reg)
                begin
                    result_next = head.main;
                    if (head.has_count)
                    begin
                        main_done_next = 1'b1;
                    end
                    else
                    begin
                        pop = 1'b1;
                    end
                end
                else
                begin
                    result_next               = '0;
                    result_next.kind          = KIND_COUNT;
                    result_next.message_total = head.total;
                    main_done_next            = 1'b0;
                    pop                       = 1'b1;
                end
            end
        end

        wr_ptr_next = push ? wr_ptr_reg + QUEUE_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QUEUE_PTR_W'(1) : rd_ptr_reg;

        unique case ({push, pop})
            2'b10:   count_next = count_reg + QUEUE_CNT_W'(1);
            2'b01:   count_next = count_reg - QUEUE_CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule

`default_nettype wire

### hw/rtl/timestamped_mavlink_frame_parser.sv
// Top level of the timestamped MAVLink log framer.
//
// The block takes a telemetry log one byte per word on the input channel
// (data_byte, end_of_stream) and delivers result words on the output channel.
// Each record is an 8-byte big-endian timestamp followed by a v1 or v2 MAVLink
// frame. For each framed message it sends a header word (kind 0) and then one
// word per payload byte (kind 1) while the max_reports limit allows; the byte
// flagged end_of_stream also yields a message count word (kind 2) and clears
// the parser so the next stream starts clean.
// Throughput is one input word per cycle while in_stall is low. An accepted word
// is decoded in the input register stage and its results pass through the result
// queue to the output register. An end-of-stream byte that also yields a header
// or payload word gives two output words.
// A four-entry result queue separates the sides; when it cannot take what is
// already in flight, in_stall rises. A stalled output word holds steady.
// The configuration channel writes max_reports whenever cfg_valid is high;
// cfg_ready is always high. Reset sets max_reports to all ones and returns the
// parser to collecting a timestamp with all counts at zero.
`default_nettype none

module timestamped_mavlink_frame_parser #(
    parameter int COUNT_WIDTH = tmfp_pkg::DEFAULT_COUNT_WIDTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        end_of_stream,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [63:0] timestamp,
    output logic [23:0] message_id,
    output logic [7:0]  payload_length,
    output logic [7:0]  payload_byte,
    output logic        last_of_message,
    output logic [31:0] message_total,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);
    import tmfp_pkg::*;

    logic [31:0]        max_reports_reg;
    logic               push;
    tmfp_entry_t        entry;
    tmfp_queue_status_t queue_status;
    tmfp_result_t       result;

    // The only register; cfg_ready is always high, so every write is taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reports_reg <= 32'hFFFF_FFFF;
        end
        else if (cfg_valid && cfg_ready)
        begin
            max_reports_reg <= cfg_data;
        end
    end

    // Per-byte framing: input register, parser state and result building.
    tmfp_frame_decoder #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_decoder (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .end_of_stream (end_of_stream),
        .max_reports   (max_reports_reg),
        .queue_status  (queue_status),
        .push          (push),
        .entry         (entry)
    );

    // Queue and output register: splits an entry into one or two words.
    tmfp_result_queue u_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .entry        (entry),
        .queue_status (queue_status),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result       (result)
    );

    assign kind            = result.kind;
    assign timestamp       = result.timestamp;
    assign message_id      = result.message_id;
    assign payload_length  = result.payload_length;
    assign payload_byte    = result.payload_byte;
    assign last_of_message = result.last_of_message;
    assign message_total   = result.message_total;

    // The decoder never writes into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n) push |-> !queue_status.full)
        else $error("result queue overflow");

    // A full queue always holds off the input channel.
    assert property (@(posedge clk) disable iff (!rst_n) queue_status.full |-> in_stall)
        else $error("input accepted while result queue is full");

    // A header word of an empty message also closes that message.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == KIND_HEADER && payload_length == 8'd0) |-> last_of_message)
        else $error("empty message header without last_of_message");

endmodule

`default_nettype wire

### test/tb_top.sv
// Self-checking testbench of the timestamped MAVLink log framer: random framed logs, stalls, limits.
`timescale 1ns / 1ps

module tb_top;
    import tmfp_pkg::*;

    // Cycles without any accepted word, checked result or config write before the run is declared hung.
    localparam int HANG_LIMIT = 4000;
    // Quiet cycles after the last result, enough to cover the pipeline.
    localparam int DRAIN_CYCLES = 10;
    localparam int LIMIT_PHASES = 8;
    localparam int BYTES_PER_PHASE = 175;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       stream_end;
    } log_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = 8'h00;
    logic        end_of_stream = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  kind;
    logic [63:0] timestamp;
    logic [23:0] message_id;
    logic [7:0]  payload_length;
    logic [7:0]  payload_byte;
    logic        last_of_message;
    logic [31:0] message_total;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data = 32'h0;

    // Bytes waiting to be driven and result words waiting to be seen.
    log_byte_t    log_bytes [$];
    tmfp_result_t framed_words [$];
    log_byte_t    sent_byte;
    tmfp_result_t want_word;

    // Local copy of the framer state, kept in step with the accepted bytes.
    logic [31:0] report_cap = 32'hFFFF_FFFF;
    logic [63:0] ts_window = '0;
    logic [3:0]  ts_fill = '0;
    tmfp_phase_t parse_phase = PH_TIME;
    logic        frame_v2 = 1'b0;
    logic [3:0]  hdr_pos = '0;
    logic [7:0]  msg_len = '0;
    logic [7:0]  msg_flags = '0;
    logic [23:0] msg_id = '0;
    logic [8:0]  skip_left = '0;
    logic        reporting = 1'b0;
    logic [31:0] frames_counted = '0;
    logic [31:0] reports_done = '0;

    int error_count = 0;
    int idle_cycles = 0;
    int bytes_queued = 0;
    int in_gap = 0;
    int in_burst = 0;
    int stall_left = 0;
    int out_burst = 0;
    bit in_word_taken = 1'b0;
    bit busy;

    timestamped_mavlink_frame_parser i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .data_byte       (data_byte),
        .end_of_stream   (end_of_stream),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .kind            (kind),
        .timestamp       (timestamp),
        .message_id      (message_id),
        .payload_length  (payload_length),
        .payload_byte    (payload_byte),
        .last_of_message (last_of_message),
        .message_total   (message_total),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    task automatic note_error(input string msg);
        error_count++;
        $display("ERROR at %0t: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            note_error($sformatf("%s got %0h, want %0h", name, got, want));
    endtask

    function automatic logic [8:0] trailer_bytes();
        // Checksum always; the signature only on v2 frames with the signed flag.
        return CHECKSUM_LEN +
               ((frame_v2 && (msg_flags & FLAG_SIGNED) != 8'h00) ? SIGNATURE_LEN : 9'd0);
    endfunction

    // Advances the local framer state by one byte and queues the words it yields.
    task automatic frame_byte(input logic [7:0] b, input logic eos);
        tmfp_result_t word;
        logic         done;
        case (parse_phase)
            PH_TIME: begin
                if (ts_fill >= TS_BYTES && (b == MARKER_V2 || b == MARKER_V1)) begin
                    frame_v2 = (b == MARKER_V2);
                    hdr_pos = 4'd1;
                    msg_len = '0;
                    msg_flags = '0;
                    msg_id = '0;
                    parse_phase = PH_HEADER;
                end
                else begin
                    // Short window fills up; a full one slides to resync.
                    ts_window = {ts_window[55:0], b};
                    if (ts_fill < TS_BYTES)
                        ts_fill++;
                end
            end
            PH_HEADER: begin
                if (hdr_pos == HDR_LEN_AT)
                    msg_len = b;
                if (frame_v2) begin
                    if (hdr_pos == HDR_FLAGS_AT)
                        msg_flags = b;
                    if (hdr_pos == V2_ID_LO_AT)
                        msg_id = {16'h0, b};
                    if (hdr_pos == V2_ID_MID_AT)
                        msg_id = msg_id | ({16'h0, b} << 8);
                    if (hdr_pos == V2_ID_HI_AT)
                        msg_id = msg_id | ({16'h0, b} << 16);
                    done = (hdr_pos >= V2_HEADER_LAST);
                end
                else begin
                    if (hdr_pos == V1_ID_AT)
                        msg_id = {16'h0, b};
                    done = (hdr_pos >= V1_HEADER_LAST);
                end
                if (!done) begin
                    hdr_pos++;
                end
                else begin
                    if (frames_counted != 32'hFFFF_FFFF)
                        frames_counted++;
                    reporting = (reports_done < report_cap);
                    if (reporting) begin
                        word = '0;
                        word.kind = KIND_HEADER;
                        word.timestamp = ts_window;
                        word.message_id = msg_id;
                        word.payload_length = msg_len;
                        word.last_of_message = (msg_len == 8'h00);
                        framed_words.push_back(word);
                        reports_done++;
                    end
                    if (msg_len != 8'h00) begin
                        parse_phase = PH_PAYLOAD;
                        skip_left = {1'b0, msg_len};
                    end
                    else begin
                        parse_phase = PH_TRAILER;
                        skip_left = trailer_bytes();
                    end
                end
            end
            PH_PAYLOAD: begin
                if (reporting) begin
                    word = '0;
                    word.kind = KIND_PAYLOAD;
                    word.timestamp = ts_window;
                    word.message_id = msg_id;
                    word.payload_length = msg_len;
                    word.payload_byte = b;
                    word.last_of_message = (skip_left <= 9'd1);
                    framed_words.push_back(word);
                end
                if (skip_left != 9'd0)
                    skip_left--;
                if (skip_left == 9'd0) begin
                    parse_phase = PH_TRAILER;
                    skip_left = trailer_bytes();
                end
            end
            PH_TRAILER: begin
                if (skip_left != 9'd0)
                    skip_left--;
                if (skip_left == 9'd0) begin
                    parse_phase = PH_TIME;
                    ts_fill = '0;
                    ts_window = '0;
                    reporting = 1'b0;
                end
            end
            default: begin
                parse_phase = PH_TIME;
                ts_fill = '0;
                ts_window = '0;
            end
        endcase
        if (eos) begin
            // The count word trails any header or payload word of this byte.
            word = '0;
            word.kind = KIND_COUNT;
            word.message_total = frames_counted;
            framed_words.push_back(word);
            ts_window = '0;
            ts_fill = '0;
            parse_phase = PH_TIME;
            frame_v2 = 1'b0;
            hdr_pos = '0;
            msg_len = '0;
            msg_flags = '0;
            msg_id = '0;
            skip_left = '0;
            reporting = 1'b0;
            frames_counted = '0;
            reports_done = '0;
        end
    endtask

    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic add_byte(input logic [7:0] b, input logic eos);
        log_byte_t item;
        item.byte_value = b;
        item.stream_end = eos;
        log_bytes.push_back(item);
        bytes_queued++;
    endtask

    // Queues one timestamped frame; a cut-short frame ends the stream mid-record.
    task automatic add_record(input bit cut_short);
        logic [7:0] frame [$];
        logic [7:0] flags;
        logic [7:0] len;
        int         ts_style;
        int         keep;
        int         r;
        bit         v2;
        v2 = 1'($urandom_range(0, 1));
        flags = rand_byte();
        ts_style = $urandom_range(0, 5);
        r = $urandom_range(0, 99);
        if (r < 15)
            len = 8'd0;
        else if (r < 90)
            len = 8'($urandom_range(1, 12));
        else if (r < 97)
            len = 8'($urandom_range(13, 64));
        else
            len = $urandom_range(0, 1) ? 8'd255 : 8'($urandom_range(65, 254));
        for (int i = 0; i < 8; i++)
            frame.push_back(ts_style == 0 ? 8'h00 : ts_style == 1 ? 8'hFF : rand_byte());
        frame.push_back(v2 ? MARKER_V2 : MARKER_V1);
        frame.push_back(len);
        if (v2) begin
            // Incompatibility flags, then compat flags, sequence, system,
            // component and the three id bytes.
            frame.push_back(flags);
            repeat (7) frame.push_back(rand_byte());
        end
        else begin
            // Sequence, system, component and the id byte.
            repeat (4) frame.push_back(rand_byte());
        end
        repeat (len) frame.push_back(rand_byte());
        repeat (2) frame.push_back(rand_byte());
        if (v2 && flags[0])
            repeat (13) frame.push_back(rand_byte());
        keep = cut_short ? $urandom_range(1, frame.size() - 1) : frame.size();
        for (int i = 0; i < keep; i++)
            add_byte(frame[i], cut_short && (i == keep - 1));
    endtask

    task automatic wait_idle();
        while (log_bytes.size() != 0 || in_valid)
            @(posedge clk);
        while (framed_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Input driver: a word is held until taken, then an optional gap follows.
    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_word_taken) begin
            if (in_gap > 0) begin
                in_gap--;
                in_valid <= 1'b0;
            end
            else if (log_bytes.size() != 0) begin
                sent_byte = log_bytes.pop_front();
                in_valid <= 1'b1;
                data_byte <= sent_byte.byte_value;
                end_of_stream <= sent_byte.stream_end;
                if (in_burst > 0) begin
                    in_burst--;
                    in_gap = 0;
                end
                else begin
                    in_gap = idle_length();
                    if ($urandom_range(0, 99) == 0)
                        in_burst = $urandom_range(30, 120);
                end
            end
            else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Output back-pressure with its own runs of stalls and stall-free stretches.
    always @(negedge clk) begin
        if (stall_left > 0) begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else begin
            out_stall <= 1'b0;
            if (out_burst > 0) begin
                out_burst--;
            end
            else begin
                stall_left = idle_length();
                if ($urandom_range(0, 99) == 0)
                    out_burst = $urandom_range(30, 120);
            end
        end
    end

    // Monitor: results are checked before the byte taken at the same edge is
    // predicted, since that byte cannot have reached the output yet.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_word_taken = 1'b0;
        end
        else begin
            busy = 1'b0;
            in_word_taken = in_valid && !in_stall;
            if (out_valid && !out_stall) begin
                busy = 1'b1;
                if (framed_words.size() == 0) begin
                    note_error($sformatf("unexpected result word of kind %0d", kind));
                end
                else begin
                    want_word = framed_words.pop_front();
                    check_field("kind", 64'(kind), 64'(want_word.kind));
                    check_field("timestamp", timestamp, want_word.timestamp);
                    check_field("message_id", 64'(message_id), 64'(want_word.message_id));
                    check_field("payload_length", 64'(payload_length),
                                64'(want_word.payload_length));
                    check_field("payload_byte", 64'(payload_byte),
                                64'(want_word.payload_byte));
                    check_field("last_of_message", 64'(last_of_message),
                                64'(want_word.last_of_message));
                    check_field("message_total", 64'(message_total),
                                64'(want_word.message_total));
                end
            end
            if (in_word_taken) begin
                busy = 1'b1;
                frame_byte(data_byte, end_of_stream);
            end
            if (cfg_valid && cfg_ready) begin
                busy = 1'b1;
                report_cap = cfg_data;
            end
            idle_cycles = busy ? 0 : idle_cycles + 1;
        end
    end

    initial begin
        while (idle_cycles < HANG_LIMIT)
            @(posedge clk);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        logic [31:0] cap;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed opening at the reset limit. Markers inside a short window
        // are plain timestamp bytes; a non-marker after a full window slides it.
        add_byte(MARKER_V2, 1'b0);
        add_byte(MARKER_V1, 1'b0);
        repeat (6) add_byte(8'hFF, 1'b0);
        add_byte(8'h00, 1'b0);
        // A v1 frame with an empty payload and the top id, then its checksum.
        add_byte(MARKER_V1, 1'b0);
        repeat (4) add_byte(8'h00, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'hFF, 1'b0);
        // Stream ends right after the frame, then an empty stream ends at once.
        add_byte(8'h00, 1'b1);
        add_byte(8'hFF, 1'b1);
        wait_idle();

        for (int p = 0; p < LIMIT_PHASES; p++) begin
            case (p)
                0: cap = 32'd0;
                1: cap = 32'd1;
                2: cap = 32'hFFFF_FFFF;
                3: cap = 32'd2;
                4: cap = $urandom;
                5: cap = 32'hFFFF_FFFE;
                6: cap = $urandom_range(0, 5);
                default: cap = 32'd3;
            endcase
            // The limit is only changed while the framer has nothing in flight.
            @(negedge clk);
            cfg_valid <= 1'b1;
            cfg_data <= cap;
            do
                @(posedge clk);
            while (!cfg_ready);
            @(negedge clk);
            cfg_valid <= 1'b0;

            while (bytes_queued < (p + 1) * BYTES_PER_PHASE) begin
                case ($urandom_range(0, 9))
                    0: repeat ($urandom_range(1, 10)) add_byte(rand_byte(), 1'b0);
                    1: add_record(1'b1);
                    default: add_record(1'b0);
                endcase
            end
            // Most phases close their stream; the rest carry state into the next.
            if ($urandom_range(0, 3) != 0)
                add_byte(rand_byte(), 1'b1);
            wait_idle();
        end

        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
